// ===== rtl/btex_pkg.sv =====
// Package for the bilinear texture sampler: sizes, codes, shared types and
// the divide-by-255 helper. No dependencies.
`default_nettype none
package btex_pkg;

   localparam int MAX_TEXELS       = 4096;
   localparam int ADDR_W           = $clog2(MAX_TEXELS);
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int TOP_W            = 8 + WEIGHT_FRAC_BITS;
   localparam int BLEND_W          = 8 + 2 * WEIGHT_FRAC_BITS;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CSR_PRESENT = 2'd0,
      CSR_WIDTH   = 2'd1,
      CSR_HEIGHT  = 2'd2,
      CSR_NONE    = 2'd3
   } csr_idx_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] diff_r;
      logic [7:0] diff_g;
      logic [7:0] diff_b;
   } meta_type;

   // floor(n / 255) for n below 65280
   function automatic logic [7:0] div255(input logic [15:0] n);
      logic [16:0] sum;
      sum = {1'b0, n} + {9'd0, n[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/btex_texram.sv =====
// One bank of the texel store: one write port, one registered read port.
// Depends on btex_pkg.
`default_nettype none
module btex_texram (
   input  wire                        clock,
   input  wire                        en,
   input  wire                        wr_en,
   input  wire [btex_pkg::ADDR_W-1:0] wr_addr,
   input  wire [31:0]                 wr_data,
   input  wire [btex_pkg::ADDR_W-1:0] rd_addr,
   output logic [31:0]                rd_data
);
   import btex_pkg::*;

   logic [31:0] mem [MAX_TEXELS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/btex_lane.sv =====
// One colour lane: horizontal lerp, vertical lerp, then scale, three stages.
// Result is floor(blend * scale / S^2). Depends on btex_pkg.
`default_nettype none
module btex_lane (
   input  wire                                  clock,
   input  wire                                  en,
   input  wire [7:0]                            p00,
   input  wire [7:0]                            p10,
   input  wire [7:0]                            p01,
   input  wire [7:0]                            p11,
   input  wire [btex_pkg::WEIGHT_FRAC_BITS-1:0] wx,
   input  wire [btex_pkg::WEIGHT_FRAC_BITS-1:0] wy,
   input  wire [7:0]                            scale,
   output logic [15:0]                          result
);
   import btex_pkg::*;

   localparam int W    = WEIGHT_FRAC_BITS;
   localparam int PR_W = BLEND_W + 8;

   logic [W:0]         swx, swy;
   logic [TOP_W-1:0]   top_in, bot_in, top_ff, bot_ff;
   logic [W-1:0]       wy_ff;
   logic [7:0]         scale1_ff, scale2_ff;
   logic [BLEND_W-1:0] blend_in, blend_ff;
   logic [PR_W-1:0]    prod;
   logic [15:0]        result_ff;

   assign swx    = (W+1)'(1 << W) - {1'b0, wx};
   assign top_in = TOP_W'(p00 * swx + p10 * wx);
   assign bot_in = TOP_W'(p01 * swx + p11 * wx);

   assign swy      = (W+1)'(1 << W) - {1'b0, wy_ff};
   assign blend_in = BLEND_W'(top_ff * swy + bot_ff * wy_ff);

   assign prod = blend_ff * scale2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         top_ff    <= top_in;
         bot_ff    <= bot_in;
         wy_ff     <= wy;
         scale1_ff <= scale;
         blend_ff  <= blend_in;
         scale2_ff <= scale1_ff;
         result_ff <= prod[PR_W-1 -: 16];
      end
   end

   assign result = result_ff;
endmodule
`default_nettype wire

// ===== rtl/bilinear_texture_sampler.sv =====
// Top level of the bilinear texture sampler: coordinate pipeline, four texel
// banks, four colour lanes, output register. Depends on btex_pkg, btex_texram, btex_lane.
//
//   channel | dir | handshake          | carries
//   req_    | in  | valid / stall      | write texel or sample u,v with diffuse
//   rsp_    | out | valid / stall      | filtered RGBA, one word per sample
//   csr_    | in  | valid / ready      | register index and data
//
// Eight register levels, the last of which drives rsp_valid; one word
// accepted per cycle while req_stall is low.
// The four neighbor reads come from four copies of the texel store, all
// written together, so one sample fetches its quad with one read of each bank.
// The whole pipeline holds while a result waits under rsp_stall; req_stall
// is then high. Reset clears the valid bits and the configuration registers only; the
// texel store needs no clearing pass.
`default_nettype none
module bilinear_texture_sampler (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_opcode,
   input  wire [11:0]  req_texel_index,
   input  wire [7:0]   req_texel_red,
   input  wire [7:0]   req_texel_green,
   input  wire [7:0]   req_texel_blue,
   input  wire [7:0]   req_texel_alpha,
   input  wire signed [31:0] req_u_coord,
   input  wire signed [31:0] req_v_coord,
   input  wire [7:0]   req_diffuse_red,
   input  wire [7:0]   req_diffuse_green,
   input  wire [7:0]   req_diffuse_blue,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic [7:0]  rsp_out_alpha,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [1:0]   csr_index,
   input  wire [6:0]   csr_wdata
);
   import btex_pkg::*;

   localparam int W = WEIGHT_FRAC_BITS;

   // ---------------- configuration ----------------
   logic       present_ff;
   logic [6:0] width_ff, height_ff;
   logic [6:0] wm1, hm1, weff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         width_ff   <= 7'd1;
         height_ff  <= 7'd1;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_PRESENT: present_ff <= csr_wdata[0];
            CSR_WIDTH:   width_ff   <= csr_wdata;
            CSR_HEIGHT:  height_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a size of zero acts as one
   assign wm1  = (width_ff  == 7'd0) ? 7'd0 : width_ff  - 7'd1;
   assign hm1  = (height_ff == 7'd0) ? 7'd0 : height_ff - 7'd1;
   assign weff = wm1 + 7'd1;

   // ---------------- flow control ----------------
   // Everything advances together unless a finished word is held.
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   logic     vld_ff  [1:7];
   meta_type meta_ff [1:7];
   meta_type meta_in;

   assign meta_in = '{op:     op_type'(req_opcode),
                      diff_r: req_diffuse_red,
                      diff_g: req_diffuse_green,
                      diff_b: req_diffuse_blue};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 7; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[1] <= req_valid;
         for (int i = 2; i <= 7; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[1] <= meta_in;
         for (int i = 2; i <= 7; i++) meta_ff[i] <= meta_ff[i-1];
      end
   end

   // ---------------- stage 1: scale the wrapped fractions ----------------
   // u uses its fraction; v is flipped to 1 - fraction (1..65536).
   logic [16:0]       vflip;
   logic [22:0]       fx_in, fx_ff;
   logic [23:0]       fy_in, fy_ff;
   logic [ADDR_W-1:0] idx1_ff, idx2_ff, idx3_ff;
   logic [31:0]       word1_ff, word2_ff, word3_ff;

   assign vflip = 17'h10000 - {1'b0, req_v_coord[15:0]};
   assign fx_in = req_u_coord[15:0] * wm1;
   assign fy_in = vflip * hm1;

   always_ff @(posedge clock) begin
      if (adv) begin
         fx_ff    <= fx_in;
         fy_ff    <= fy_in;
         idx1_ff  <= ADDR_W'(req_texel_index);
         word1_ff <= {req_texel_alpha, req_texel_blue, req_texel_green, req_texel_red};
      end
   end

   // ---------------- stage 2: neighbors and weights ----------------
   logic [7:0]   x0_raw, y0_raw;
   logic [6:0]   x0_in, y0_in, x1_in, y1_in;
   logic [6:0]   x0_ff, y0_ff, x1_ff, y1_ff;
   logic [W-1:0] wx2_ff, wy2_ff, wx3_ff, wy3_ff, wx4_ff, wy4_ff;

   assign x0_raw = {1'b0, fx_ff[22:16]};
   assign y0_raw = fy_ff[23:16];
   assign x0_in  = (x0_raw > {1'b0, wm1}) ? wm1 : x0_raw[6:0];
   assign y0_in  = (y0_raw > {1'b0, hm1}) ? hm1 : y0_raw[6:0];
   assign x1_in  = ({1'b0, x0_in} + 8'd1 > {1'b0, wm1}) ? wm1 : x0_in + 7'd1;
   assign y1_in  = ({1'b0, y0_in} + 8'd1 > {1'b0, hm1}) ? hm1 : y0_in + 7'd1;

   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff    <= x0_in;
         y0_ff    <= y0_in;
         x1_ff    <= x1_in;
         y1_ff    <= y1_in;
         wx2_ff   <= fx_ff[15 -: W];
         wy2_ff   <= fy_ff[15 -: W];
         idx2_ff  <= idx1_ff;
         word2_ff <= word1_ff;
      end
   end

   // ---------------- stage 3: row-major addresses ----------------
   logic [13:0]       row0, row1;
   logic [ADDR_W-1:0] addr_in [4];
   logic [ADDR_W-1:0] addr_ff [4];

   assign row0 = y0_ff * weff;
   assign row1 = y1_ff * weff;
   assign addr_in[0] = ADDR_W'(row0 + 14'(x0_ff));   // p00
   assign addr_in[1] = ADDR_W'(row0 + 14'(x1_ff));   // p10
   assign addr_in[2] = ADDR_W'(row1 + 14'(x0_ff));   // p01
   assign addr_in[3] = ADDR_W'(row1 + 14'(x1_ff));   // p11

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) addr_ff[i] <= addr_in[i];
         wx3_ff   <= wx2_ff;
         wy3_ff   <= wy2_ff;
         idx3_ff  <= idx2_ff;
         word3_ff <= word2_ff;
         wx4_ff   <= wx3_ff;
         wy4_ff   <= wy3_ff;
      end
   end

   // ---------------- stage 4: texel fetch ----------------
   // Writes land in the same stage as reads, so program order is kept.
   logic        wr_en;
   logic [31:0] texel [4];

   assign wr_en = adv && vld_ff[3] && (meta_ff[3].op == OP_WRITE);

   for (genvar b = 0; b < 4; b++) begin : g_bank
      btex_texram u_bank (
         .clock   (clock),
         .en      (adv),
         .wr_en   (wr_en),
         .wr_addr (idx3_ff),
         .wr_data (word3_ff),
         .rd_addr (addr_ff[b]),
         .rd_data (texel[b])
      );
   end

   // ---------------- stages 5-7: blend lanes ----------------
   // Alpha runs with scale 255 so the shared divide gives floor(blend).
   logic [7:0]  lane_scale [4];
   logic [15:0] lane_n     [4];

   assign lane_scale[0] = meta_ff[4].diff_r;
   assign lane_scale[1] = meta_ff[4].diff_g;
   assign lane_scale[2] = meta_ff[4].diff_b;
   assign lane_scale[3] = 8'd255;

   for (genvar k = 0; k < 4; k++) begin : g_lane
      btex_lane u_lane (
         .clock  (clock),
         .en     (adv),
         .p00    (texel[0][8*k +: 8]),
         .p10    (texel[1][8*k +: 8]),
         .p01    (texel[2][8*k +: 8]),
         .p11    (texel[3][8*k +: 8]),
         .wx     (wx4_ff),
         .wy     (wy4_ff),
         .scale  (lane_scale[k]),
         .result (lane_n[k])
      );
   end

   // ---------------- output register ----------------
   logic [7:0] out_r_ff, out_g_ff, out_b_ff, out_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[7] && (meta_ff[7].op == OP_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (present_ff) begin
            out_r_ff <= div255(lane_n[0]);
            out_g_ff <= div255(lane_n[1]);
            out_b_ff <= div255(lane_n[2]);
            out_a_ff <= div255(lane_n[3]);
         end else begin
            out_r_ff <= meta_ff[7].diff_r;
            out_g_ff <= meta_ff[7].diff_g;
            out_b_ff <= meta_ff[7].diff_b;
            out_a_ff <= 8'd255;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = out_r_ff;
   assign rsp_out_green = out_g_ff;
   assign rsp_out_blue  = out_b_ff;
   assign rsp_out_alpha = out_a_ff;

   // ---------------- checks ----------------
   // a held result freezes the input side
   a_hold_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input accepted while result held");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the store is only written while the pipeline moves
   a_write_moves: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !req_stall)
      else $error("texel write during stall");

endmodule
`default_nettype wire
